FILE: sv/olv_pkg.sv
package olv_pkg;

  localparam int unsigned ART_W = 32;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_NAME_LO = 8'd33;
  localparam logic [7:0] CH_NAME_HI = 8'd126;

  localparam logic [3:0] FLD_NUMBER = 4'd0;
  localparam logic [3:0] FLD_DIGITS = 4'd6;
  localparam logic [3:0] FLD_NEEDED = 4'd7;
  localparam logic [3:0] FLD_EXTRA  = 4'd8;
  localparam logic [3:0] FLD_MAX    = 4'd15;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_COLON   = 3'd2;
  localparam logic [2:0] PH_VALUE   = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_STARTCR = 3'd5;

  typedef struct packed {
    logic [7:0]       line_byte;
    logic             last_byte;
    logic [ART_W-1:0] article_number;
  } item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       cr_pending;
    logic       fail;
  } text_t;

endpackage

FILE: sv/olv_if.sv
interface olv_in_if;
  import olv_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       line_byte;
  logic             last_byte;
  logic [ART_W-1:0] article_number;

  modport source (output valid, line_byte, last_byte, article_number, input ready);
  modport sink (input valid, line_byte, last_byte, article_number, output ready);
endinterface

interface olv_out_if;
  logic valid;
  logic ready;
  logic line_valid;

  modport source (output valid, line_valid, input ready);
  modport sink (input valid, line_valid, output ready);
endinterface

FILE: sv/overview_line_validator.sv
// A byte marked last is held in the input register, and its verdict is then registered in the output register.
// Throughput: one byte per cycle; the input register and the line state update
// in the same cycle, so only a stalled output register with a last byte waiting holds up the input.
// Reset: synchronous, active low; it empties both registers and clears the
// line state, so the first byte after reset starts a new line.
module overview_line_validator #(
  parameter int NUMBER_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  olv_in_if.sink     in_chan,
  olv_out_if.source  out_chan
);
  import olv_pkg::*;

  logic  s_valid_r;
  item_t s_item_r;
  logic  s_go;
  logic  out_valid_r;
  logic  out_line_r;
  logic  verdict;

  assign s_go = s_valid_r && (!s_item_r.last_byte || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s_valid_r || s_go;

  olv_step #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s_go),
    .item    (s_item_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s_valid_r <= in_chan.valid;
      end
      if (s_go && s_item_r.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s_item_r.line_byte      <= in_chan.line_byte;
      s_item_r.last_byte      <= in_chan.last_byte;
      s_item_r.article_number <= in_chan.article_number;
    end
    if (s_go && s_item_r.last_byte) begin
      out_line_r <= verdict;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.line_valid = out_line_r;

endmodule

FILE: sv/olv_step.sv
module olv_step #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  olv_pkg::item_t item,
  output logic           verdict
);
  import olv_pkg::*;

  localparam int CMP_W = (NUMBER_WIDTH > ART_W) ? NUMBER_WIDTH : ART_W;
  localparam int PROD_W = NUMBER_WIDTH + 4;

  logic [3:0]              field_r, field_nxt;
  logic [2:0]              phase_r, phase_nxt;
  logic                    crp_r, crp_nxt;
  logic [NUMBER_WIDTH-1:0] num_r, num_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    fail_r, fail_nxt;
  logic                    nul_r, nul_nxt;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       num_ext;
  text_t                   txt;

  function automatic text_t value_byte(input logic [2:0] ph, input logic crp,
                                       input logic [7:0] b);
    text_t r;
    r.phase      = ph;
    r.cr_pending = crp;
    r.fail       = 1'b0;
    if (ph == PH_DONE) begin
      r.fail = 1'b1;
    end else if (crp) begin
      if (b == CH_LF) begin
        r.phase      = PH_DONE;
        r.cr_pending = 1'b0;
      end else begin
        r.fail = 1'b1;
      end
    end else if (b == CH_CR) begin
      r.cr_pending = 1'b1;
    end else if (b == CH_LF) begin
      r.fail = 1'b1;
    end
    return r;
  endfunction

  function automatic text_t full_byte(input logic [2:0] ph, input logic crp,
                                      input logic [7:0] b);
    text_t r;
    logic  name_ok;
    name_ok      = (b >= CH_NAME_LO) && (b <= CH_NAME_HI);
    r.phase      = ph;
    r.cr_pending = crp;
    r.fail       = 1'b0;
    unique case (ph)
      PH_START: begin
        if (b == CH_CR) r.phase = PH_STARTCR;
        else if (b == CH_COLON) r.phase = PH_COLON;
        else if (name_ok) r.phase = PH_NAME;
        else r.fail = 1'b1;
      end
      PH_STARTCR: begin
        if (b == CH_LF) r.phase = PH_DONE;
        else r.fail = 1'b1;
      end
      PH_NAME: begin
        if (b == CH_COLON) r.phase = PH_COLON;
        else if (!name_ok) r.fail = 1'b1;
      end
      PH_COLON: begin
        if (b == CH_SPACE) r.phase = PH_VALUE;
        else r.fail = 1'b1;
      end
      default: r = value_byte(ph, crp, b);
    endcase
    return r;
  endfunction

  function automatic logic close_fail(input logic [3:0] fld, input logic [2:0] ph,
                                      input logic crp, input logic [NUMBER_WIDTH-1:0] num,
                                      input logic ovf, input logic [ART_W-1:0] art);
    logic f;
    f = 1'b0;
    if (fld == FLD_NUMBER) begin
      f = ovf || (CMP_W'(num) != CMP_W'(art));
    end else if (fld < FLD_DIGITS) begin
      f = crp;
    end else if (fld >= FLD_EXTRA) begin
      f = crp || (ph == PH_NAME) || (ph == PH_COLON) || (ph == PH_STARTCR);
    end
    return f;
  endfunction

  assign num_ext = PROD_W'(num_r);
  assign prod    = (num_ext << 3) + (num_ext << 1) + PROD_W'(item.line_byte - CH_ZERO);

  always_comb begin
    field_nxt = field_r;
    phase_nxt = phase_r;
    crp_nxt   = crp_r;
    num_nxt   = num_r;
    ovf_nxt   = ovf_r;
    fail_nxt  = fail_r;
    nul_nxt   = nul_r;
    txt       = '0;

    if (!nul_r) begin
      if (item.line_byte == CH_NUL || item.line_byte == CH_TAB) begin
        if (close_fail(field_r, phase_r, crp_r, num_r, ovf_r, item.article_number)) begin
          fail_nxt = 1'b1;
        end
        crp_nxt   = 1'b0;
        phase_nxt = PH_START;
        if (item.line_byte == CH_NUL) begin
          nul_nxt = 1'b1;
        end else if (field_r != FLD_MAX) begin
          field_nxt = field_r + 4'd1;
        end
      end else if (field_r == FLD_NUMBER) begin
        if (item.line_byte < CH_ZERO || item.line_byte > CH_NINE) begin
          fail_nxt = 1'b1;
        end else if (!ovf_r) begin
          if (prod[PROD_W-1:NUMBER_WIDTH] != 4'd0) begin
            ovf_nxt = 1'b1;
            num_nxt = '1;
          end else begin
            num_nxt = prod[NUMBER_WIDTH-1:0];
          end
        end
      end else if (field_r == FLD_DIGITS) begin
        if (item.line_byte < CH_ZERO || item.line_byte > CH_NINE) fail_nxt = 1'b1;
      end else if (field_r < FLD_DIGITS) begin
        txt       = value_byte(phase_r, crp_r, item.line_byte);
        phase_nxt = txt.phase;
        crp_nxt   = txt.cr_pending;
        if (txt.fail) fail_nxt = 1'b1;
      end else if (field_r >= FLD_EXTRA) begin
        txt       = full_byte(phase_r, crp_r, item.line_byte);
        phase_nxt = txt.phase;
        crp_nxt   = txt.cr_pending;
        if (txt.fail) fail_nxt = 1'b1;
      end
    end

    if (!nul_nxt &&
        close_fail(field_nxt, phase_nxt, crp_nxt, num_nxt, ovf_nxt, item.article_number)) begin
      verdict = 1'b0;
    end else begin
      verdict = !fail_nxt && (field_nxt >= FLD_NEEDED);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= FLD_NUMBER;
      phase_r <= PH_START;
      crp_r   <= 1'b0;
      num_r   <= '0;
      ovf_r   <= 1'b0;
      fail_r  <= 1'b0;
      nul_r   <= 1'b0;
    end else if (step_en) begin
      if (item.last_byte) begin
        field_r <= FLD_NUMBER;
        phase_r <= PH_START;
        crp_r   <= 1'b0;
        num_r   <= '0;
        ovf_r   <= 1'b0;
        fail_r  <= 1'b0;
        nul_r   <= 1'b0;
      end else begin
        field_r <= field_nxt;
        phase_r <= phase_nxt;
        crp_r   <= crp_nxt;
        num_r   <= num_nxt;
        ovf_r   <= ovf_nxt;
        fail_r  <= fail_nxt;
        nul_r   <= nul_nxt;
      end
    end
  end

endmodule

FILE: sv/olv_checker.sv
module olv_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_line_valid
);

  // A verdict that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_valid))
    else $error("verdict dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict present after reset");

  // With the output side free the block must take bytes.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

  // A new verdict needs an accepted byte or a stalled input at the earlier sample that $past looks back to.
  a_verdict_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 2))
    else $error("verdict without input");

endmodule

bind overview_line_validator olv_checker u_olv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_line_valid (out_chan.line_valid)
);

FILE: test/overview_line_validator_test.sv
module overview_line_validator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olv_pkg::*;

  class verdict_board;
    logic [3:0]       field_idx;
    logic [2:0]       phase;
    bit               cr_wait;
    logic [ART_W-1:0] num_val;
    bit               num_ovf;
    bit               failed;
    bit               nul_hit;
    bit               expected_verdicts[$];
    int               mismatches;

    function new();
      clear_line();
      mismatches = 0;
    endfunction

    function void clear_line();
      field_idx = FLD_NUMBER;
      phase = PH_START;
      cr_wait = 0;
      num_val = '0;
      num_ovf = 0;
      failed = 0;
      nul_hit = 0;
    endfunction

    // Value text allows only one CRLF, and only as the end of the field.
    function void text_byte(logic [7:0] b);
      if (phase == PH_DONE) begin
        failed = 1;
      end else if (cr_wait) begin
        if (b == CH_LF) begin
          phase = PH_DONE;
          cr_wait = 0;
        end else begin
          failed = 1;
        end
      end else if (b == CH_CR) begin
        cr_wait = 1;
      end else if (b == CH_LF) begin
        failed = 1;
      end
    endfunction

    function void extra_byte(logic [7:0] b);
      case (phase)
        PH_START: begin
          if (b == CH_CR) phase = PH_STARTCR;
          else if (b == CH_COLON) phase = PH_COLON;
          else if (b >= CH_NAME_LO && b <= CH_NAME_HI) phase = PH_NAME;
          else failed = 1;
        end
        PH_STARTCR: begin
          if (b == CH_LF) phase = PH_DONE;
          else failed = 1;
        end
        PH_NAME: begin
          if (b == CH_COLON) phase = PH_COLON;
          else if (!(b >= CH_NAME_LO && b <= CH_NAME_HI)) failed = 1;
        end
        PH_COLON: begin
          if (b == CH_SPACE) phase = PH_VALUE;
          else failed = 1;
        end
        default: text_byte(b);
      endcase
    endfunction

    function void content_byte(logic [7:0] b);
      logic [2*ART_W-1:0] grown;
      if (field_idx == FLD_NUMBER) begin
        if (b < CH_ZERO || b > CH_NINE) begin
          failed = 1;
        end else if (!num_ovf) begin
          grown = (2*ART_W)'(num_val) * 10 + (2*ART_W)'(b - CH_ZERO);
          if (grown > (2*ART_W)'({ART_W{1'b1}})) begin
            num_ovf = 1;
            num_val = '1;
          end else begin
            num_val = grown[ART_W-1:0];
          end
        end
      end else if (field_idx == FLD_DIGITS) begin
        if (b < CH_ZERO || b > CH_NINE) failed = 1;
      end else if (field_idx < FLD_DIGITS) begin
        text_byte(b);
      end else if (field_idx >= FLD_EXTRA) begin
        extra_byte(b);
      end
    endfunction

    function void close_field(logic [ART_W-1:0] art);
      if (field_idx == FLD_NUMBER) begin
        if (num_ovf || num_val != art) failed = 1;
      end else if (field_idx < FLD_DIGITS) begin
        if (cr_wait) failed = 1;
      end else if (field_idx >= FLD_EXTRA) begin
        if (cr_wait || phase == PH_NAME || phase == PH_COLON || phase == PH_STARTCR)
          failed = 1;
      end
      cr_wait = 0;
      phase = PH_START;
    endfunction

    function void note_byte(item_t it);
      if (!nul_hit) begin
        if (it.line_byte == CH_NUL) begin
          close_field(it.article_number);
          nul_hit = 1;
        end else if (it.line_byte == CH_TAB) begin
          close_field(it.article_number);
          if (field_idx < FLD_MAX) field_idx++;
        end else begin
          content_byte(it.line_byte);
        end
      end
      if (it.last_byte) begin
        if (!nul_hit) close_field(it.article_number);
        expected_verdicts.push_back(!failed && field_idx >= FLD_NEEDED);
        clear_line();
      end
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected line_valid, expected none, got %0b", $time, got);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: line_valid mismatch, expected %0b, got %0b", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  olv_in_if  in_chan();
  olv_out_if out_chan();

  overview_line_validator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  verdict_board board;
  logic [7:0]   line_buf[$];
  int           sent_count = 0;
  int           taken_count = 0;
  int           live_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) board.check_verdict(out_chan.line_valid);
  end

  function automatic logic [7:0] pick_byte(input bit free);
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(32, 126)) : 8'($urandom);
    end while (b == CH_NUL || b == CH_TAB || (!free && (b == CH_CR || b == CH_LF)));
    return b;
  endfunction

  task automatic load_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic [ART_W-1:0] art);
    int    gap;
    item_t it;
    gap = ((sent_count / 50) % 4 == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.line_byte <= b;
    in_chan.last_byte <= last;
    in_chan.article_number <= art;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    it.line_byte = b;
    it.last_byte = last;
    it.article_number = art;
    board.note_byte(it);
    sent_count++;
  endtask

  task automatic send_line(input logic [ART_W-1:0] art);
    int i;
    bit ended;
    ended = 0;
    for (i = 0; i < line_buf.size(); i++) begin
      if (!ended) live_count++;
      if (line_buf[i] == CH_NUL) ended = 1;
      send_byte(line_buf[i], i == line_buf.size() - 1, art);
    end
  endtask

  task automatic run_text(input string s, input logic [ART_W-1:0] art);
    line_buf.delete();
    load_str(s);
    send_line(art);
  endtask

  task automatic build_line(input logic [ART_W-1:0] art);
    int f;
    int n_extra;
    int kind;
    line_buf.delete();
    if (art != 0 || $urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_ZERO);
      load_str($sformatf("%0d", art));
    end
    for (f = 1; f <= 7; f++) begin
      line_buf.push_back(CH_TAB);
      if (f == 6) begin
        repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom_range(48, 57)));
      end else begin
        repeat ($urandom_range(0, 4)) line_buf.push_back(pick_byte(f == 7));
        if (f < 6 && $urandom_range(0, 4) == 0) begin
          line_buf.push_back(CH_CR);
          line_buf.push_back(CH_LF);
        end
      end
    end
    n_extra = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    repeat (n_extra) begin
      line_buf.push_back(CH_TAB);
      kind = $urandom_range(0, 3);
      if (kind == 1) begin
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
      end else if (kind >= 2) begin
        repeat ($urandom_range(kind == 2 ? 1 : 0, 4))
          line_buf.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(33, 57))
                                                        : 8'($urandom_range(59, 126)));
        line_buf.push_back(CH_COLON);
        line_buf.push_back(CH_SPACE);
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_byte(0));
        if ($urandom_range(0, 2) == 0) begin
          line_buf.push_back(CH_CR);
          line_buf.push_back(CH_LF);
        end
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      line_buf.push_back(CH_NUL);
      repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom));
    end
  endtask

  task automatic mutate_line(inout logic [ART_W-1:0] art);
    int pos;
    pos = $urandom_range(0, line_buf.size() - 1);
    case ($urandom_range(0, 5))
      0: line_buf[pos] = 8'($urandom);
      1: line_buf.insert(pos, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
      2: if (line_buf.size() > 1) line_buf.delete(pos);
      3: art = art ^ (ART_W'(1) << $urandom_range(0, ART_W - 1));
      4: line_buf = line_buf[0:pos];
      default: line_buf.push_front(8'($urandom_range(48, 57)));
    endcase
  endtask

  initial begin
    int hold;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken_count == 10 || taken_count == 40) hold = 400;
      else if ((taken_count / 15) % 4 == 3) hold = 0;
      else hold = $urandom_range(0, 5);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      taken_count++;
    end
  end

  initial begin
    logic [ART_W-1:0] art;
    int               lines;
    int               w;
    board = new();
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.line_byte <= '0;
    in_chan.last_byte <= 1'b0;
    in_chan.article_number <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_text("\t\t\t\t\t\t\t", 0);
    run_text("4294967295\ta\tb\tc\td\te\t123\tzz", 32'hFFFF_FFFF);
    run_text("4294967296\t\t\t\t\t\t\t", 32'hFFFF_FFFF);
    run_text("5\t\t\t\t\t\t", 5);
    run_text("12\t\t\t\t\t\t\t", 13);
    run_text("\t\t\t\t\t\t\t", 1);
    run_text("1\ta\rb\t\t\t\t\t\t", 1);
    run_text("1\t\tab\r\t\t\t\t\t", 1);
    run_text("1\t\t\tx\r\ny\t\t\t\t", 1);
    run_text("1\t\t\t\tx\r\n\t\t\t", 1);
    run_text("1\t\nab\t\t\t\t\t\t", 1);
    run_text("1\t\t\t\t\t\t1a\t", 1);
    run_text("2\t\t\t\t\t\t9\t\r\n\tXref: a b\r\n\ta: \t: v", 2);
    run_text("2\t\t\t\t\t\t\t\tXref:v", 2);
    run_text("2\t\t\t\t\t\t\t\tXref", 2);
    run_text("2\t\t\t\t\t\t\t\t\r", 2);
    run_text("\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t", 0);
    run_text("x", 0);
    line_buf.delete();
    load_str("7\t\t\t");
    line_buf.push_back(CH_NUL);
    load_str("junk\t\t\t\t");
    send_line(7);
    line_buf.delete();
    load_str("7\t\t\t\t\t\t\t");
    line_buf.push_back(CH_NUL);
    load_str("x\ty");
    send_line(7);
    line_buf.delete();
    load_str("3\t\t\t\t\t\t\t");
    line_buf.push_back(8'hFF);
    load_str("\t");
    line_buf.push_back(8'h80);
    load_str(": v");
    send_line(3);
    line_buf.delete();
    line_buf.push_back(CH_NUL);
    send_line(0);

    lines = 0;
    while (live_count < 1450 || lines < 50) begin
      case ($urandom_range(0, 3))
        0: art = $urandom;
        1: art = $urandom_range(0, 50);
        2: art = {ART_W{1'b1}} - ART_W'($urandom_range(0, 3));
        default: art = ART_W'($urandom_range(0, 99999));
      endcase
      if ($urandom_range(0, 19) == 0) begin
        line_buf.delete();
        repeat ($urandom_range(1, 12))
          line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : 8'($urandom));
      end else begin
        build_line(art);
        if ($urandom_range(0, 9) < 3) mutate_line(art);
      end
      send_line(art);
      lines++;
      if (lines % 15 == 0) begin
        in_chan.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
    end
    in_chan.valid <= 1'b0;

    for (w = 0; w < 5000 && board.pending() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: line_valid missing, expected %0d more, got none", $time, board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("overview_line_validator_test: done, clean");
    end else begin
      $display("overview_line_validator_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("overview_line_validator_test: done, errors");
    $finish;
  end

endmodule
